FILE: hw/rtl/pdks_pkg.sv
package pdks_pkg;

    localparam int K_NEAREST_DEF = 25;
    localparam int RANK_W = 6;
    localparam int VOXEL_W = 16;
    localparam int DIST_W = 48;
    localparam int SQ_W = 33;
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    localparam logic [DIST_W-1:0] CEILING_RESET = 48'd9999999;
    localparam logic CEILING_REG_IDX = 1'b0;

    typedef struct packed {
        logic take;
        logic load;
        logic [RANK_W-1:0] rank;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } status_t;

endpackage

FILE: hw/rtl/pdks_datapath.sv
module pdks_datapath
    import pdks_pkg::*;
#(
    parameter int K_NEAREST = K_NEAREST_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic signed [VOXEL_W-1:0]  cand_voxel,
    input  logic signed [VOXEL_W-1:0]  ref_voxel,
    input  logic                       is_centre,
    input  logic                       patch_end,
    input  logic                       window_end,
    input  logic                       cfg_wr,
    input  logic [DIST_W-1:0]          cfg_wdata,
    output logic [DIST_W-1:0]          ceiling,
    output logic [RANK_W-1:0]          rank,
    output logic signed [VOXEL_W-1:0]  out_value,
    output logic [DIST_W-1:0]          out_distance,
    output logic                       slot_valid,
    output logic                       last
);

    logic [DIST_W-1:0] ceiling_reg;

    // stage 1: captured item
    logic v1_reg;
    logic signed [VOXEL_W-1:0] c1_reg, r1_reg;
    logic centre1_reg, end1_reg;

    // stage 2: squared difference
    logic v2_reg;
    logic [SQ_W-1:0] sq2_reg;
    logic signed [VOXEL_W-1:0] c2_reg;
    logic centre2_reg, end2_reg;
    logic signed [VOXEL_W:0] diff1;
    logic signed [2*VOXEL_W+1:0] prod1;

    // stage 3: running sum and finished patch
    logic [DIST_W-1:0] sum_reg;
    logic signed [VOXEL_W-1:0] capture_reg;
    logic ins_valid_reg;
    logic [DIST_W-1:0] ins_dist_reg;
    logic signed [VOXEL_W-1:0] ins_val_reg;
    logic [DIST_W:0] sum_add;
    logic [DIST_W-1:0] sum_sat, sum_next;
    logic signed [VOXEL_W-1:0] capture_next;

    // sorted list
    logic [K_NEAREST-1:0] full_reg;
    logic [DIST_W-1:0] dist_reg [K_NEAREST];
    logic signed [VOXEL_W-1:0] val_reg [K_NEAREST];
    logic [K_NEAREST-1:0] cond;
    logic ins_ok;

    // output register
    logic [RANK_W-1:0] rank_reg;
    logic signed [VOXEL_W-1:0] out_value_reg;
    logic [DIST_W-1:0] out_distance_reg;
    logic slot_valid_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= CEILING_RESET;
        end else if (cfg_wr) begin
            ceiling_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ins_valid_reg <= 1'b0;
            sum_reg <= '0;
            capture_reg <= '0;
        end else begin
            v1_reg <= cmd.take;
            v2_reg <= v1_reg;
            ins_valid_reg <= v2_reg && end2_reg;
            if (v2_reg) begin
                sum_reg <= end2_reg ? '0 : sum_next;
                capture_reg <= end2_reg ? '0 : capture_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            c1_reg <= cand_voxel;
            r1_reg <= ref_voxel;
            centre1_reg <= is_centre;
            end1_reg <= patch_end || window_end;
        end
        sq2_reg <= prod1[SQ_W-1:0];
        c2_reg <= c1_reg;
        centre2_reg <= centre1_reg;
        end2_reg <= end1_reg;
        ins_dist_reg <= sum_next;
        ins_val_reg <= capture_next;
    end

    assign diff1 = (VOXEL_W+1)'(c1_reg) - (VOXEL_W+1)'(r1_reg);
    assign prod1 = diff1 * diff1;

    assign sum_add = {1'b0, sum_reg} + (DIST_W+1)'(sq2_reg);
    assign sum_sat = sum_add[DIST_W] ? '1 : sum_add[DIST_W-1:0];
    assign sum_next = centre2_reg ? sum_reg : sum_sat;
    assign capture_next = centre2_reg ? c2_reg : capture_reg;

    assign ins_ok = ins_valid_reg && (ins_dist_reg < ceiling_reg);

    always_comb begin
        for (int i = 0; i < K_NEAREST; i++) begin
            cond[i] = ins_ok && (!full_reg[i] || (ins_dist_reg < dist_reg[i]));
        end
    end

    for (genvar g = 0; g < K_NEAREST; g++) begin : g_slot
        logic prev_cond;
        logic prev_full;
        logic [DIST_W-1:0] prev_dist;
        logic signed [VOXEL_W-1:0] prev_val;
        logic nxt_full;
        logic [DIST_W-1:0] nxt_dist;
        logic signed [VOXEL_W-1:0] nxt_val;

        if (g == 0) begin : g_head
            assign prev_cond = 1'b0;
            assign prev_full = 1'b0;
            assign prev_dist = '0;
            assign prev_val = '0;
        end else begin : g_body
            assign prev_cond = cond[g-1];
            assign prev_full = full_reg[g-1];
            assign prev_dist = dist_reg[g-1];
            assign prev_val = val_reg[g-1];
        end

        if (g == K_NEAREST - 1) begin : g_tail
            assign nxt_full = 1'b0;
            assign nxt_dist = '0;
            assign nxt_val = '0;
        end else begin : g_mid
            assign nxt_full = full_reg[g+1];
            assign nxt_dist = dist_reg[g+1];
            assign nxt_val = val_reg[g+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                full_reg[g] <= 1'b0;
            end else if (cmd.load) begin
                full_reg[g] <= nxt_full;
            end else if (prev_cond) begin
                full_reg[g] <= prev_full;
            end else if (cond[g]) begin
                full_reg[g] <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                dist_reg[g] <= nxt_dist;
                val_reg[g] <= nxt_val;
            end else if (prev_cond) begin
                dist_reg[g] <= prev_dist;
                val_reg[g] <= prev_val;
            end else if (cond[g]) begin
                dist_reg[g] <= ins_dist_reg;
                val_reg[g] <= ins_val_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rank_reg <= cmd.rank;
            last_reg <= cmd.last;
            slot_valid_reg <= full_reg[0];
            out_value_reg <= full_reg[0] ? val_reg[0] : '0;
            out_distance_reg <= full_reg[0] ? dist_reg[0] : ceiling_reg;
        end
    end

    assign status.busy = v1_reg || v2_reg || ins_valid_reg;
    assign ceiling = ceiling_reg;
    assign rank = rank_reg;
    assign out_value = out_value_reg;
    assign out_distance = out_distance_reg;
    assign slot_valid = slot_valid_reg;
    assign last = last_reg;

endmodule

FILE: hw/rtl/pdks_ctrl.sv
module pdks_ctrl
    import pdks_pkg::*;
#(
    parameter int K_NEAREST = K_NEAREST_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        RUN,
        DRAIN,
        EMIT
    } state_t;

    state_t state_reg;
    logic [RANK_W-1:0] rank_reg;
    logic m_tvalid_reg;
    logic out_free;
    logic at_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign at_last = (rank_reg == RANK_W'(K_NEAREST - 1));

    assign s_tready = (state_reg == RUN);
    assign cmd.take = s_tready && s_tvalid;
    assign cmd.load = (state_reg == EMIT) && out_free;
    assign cmd.rank = rank_reg;
    assign cmd.last = at_last;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RUN;
            rank_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                RUN: begin
                    if (s_tvalid && s_tlast) begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN: begin
                    rank_reg <= '0;
                    if (!status.busy) begin
                        state_reg <= EMIT;
                    end
                end
                EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        rank_reg <= rank_reg + 1'b1;
                        if (at_last) begin
                            state_reg <= RUN;
                        end
                    end
                end
                default: begin
                    state_reg <= RUN;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/patch_distance_k_nearest_select.sv
// a window end item passes the capture, square, sum and list insert registers before the first result
// throughput: 1 item per cycle inside a window (multiply, sum and insert stages)
// window end: input pauses through drain and emit, results leave 1 per cycle when the
//   output is not stalled, by shifting the sorted cell list, which also empties it
// reset: synchronous active low, list empty, sum cleared, ceiling 9999999
module patch_distance_k_nearest_select
    import pdks_pkg::*;
#(
    parameter int K_NEAREST = K_NEAREST_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cand_voxel[15:0], ref_voxel[31:16]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // is_centre[0], patch_end[1]
    input  logic [S_USER_W-1:0]  s_tuser,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // rank[5:0], out_value[21:6], out_distance[69:22], zero[71:70]
    output logic [M_DATA_W-1:0]  m_tdata,
    // slot_valid[0]
    output logic                 m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    cmd_t cmd;
    status_t status;
    logic cfg_wr;
    logic [DIST_W-1:0] ceiling;
    logic [RANK_W-1:0] rank;
    logic signed [VOXEL_W-1:0] out_value;
    logic [DIST_W-1:0] out_distance;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == CEILING_REG_IDX);
    assign prdata = (paddr[3] == CEILING_REG_IDX) ? APB_DW'(ceiling) : '0;

    pdks_ctrl #(
        .K_NEAREST(K_NEAREST)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdks_datapath #(
        .K_NEAREST(K_NEAREST)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cand_voxel   (s_tdata[15:0]),
        .ref_voxel    (s_tdata[31:16]),
        .is_centre    (s_tuser[0]),
        .patch_end    (s_tuser[1]),
        .window_end   (s_tlast),
        .cfg_wr       (cfg_wr),
        .cfg_wdata    (pwdata[DIST_W-1:0]),
        .ceiling      (ceiling),
        .rank         (rank),
        .out_value    (out_value),
        .out_distance (out_distance),
        .slot_valid   (m_tuser),
        .last         (m_tlast)
    );

    assign m_tdata = {2'b00, out_distance, out_value, rank};

endmodule

FILE: hw/rtl/pdks_checker.sv
module pdks_checker
    import pdks_pkg::*;
#(
    parameter int K_NEAREST = K_NEAREST_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tlast,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast,
    input logic                m_tvalid,
    input logic                m_tready
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == RANK_W'(K_NEAREST - 1))))
        else $error("last flag and rank disagree");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[21:6] == '0))
        else $error("empty slot with nonzero value");

    a_window_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after window end");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind patch_distance_k_nearest_select pdks_checker #(
    .K_NEAREST(K_NEAREST)
) u_pdks_checker (.*);
